/* sv/sld_pkg.sv */
`timescale 1ns / 1ps
// sld_pkg: shared types, codes and constants of the LZ decompressor.
// No dependencies.
package sld_pkg;

    localparam int WINDOW_BYTES     = 2048;
    localparam int BYTES_PER_RESULT = 8;
    localparam int HEADER_BYTES     = 6;
    localparam int WIN_AW           = $clog2(WINDOW_BYTES);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        run_last;
        logic        stream_done;
        logic [1:0]  status;
    } t_out_item;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_PRESTART = 2'd2;

    // token kinds passed from the classifier to the executor
    typedef enum logic [2:0] {
        TK_NONE = 3'd0,
        TK_HDR  = 3'd1,
        TK_END  = 3'd2,
        TK_LIT  = 3'd3,
        TK_COPY = 3'd4
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] tbyte;
        logic [2:0] hidx;
        logic       more;
        logic [11:0] span;
        logic [8:0] len;
        logic       last;
    } t_token;

endpackage

/* sv/sld_ram.sv */
`timescale 1ns / 1ps
// sld_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/sld_front.sv */
`timescale 1ns / 1ps
// sld_front: parses the compressed byte stream into tokens for the executor.
// Depends on sld_pkg.
module sld_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  sld_pkg::t_in_item i_item,
    output sld_pkg::t_token  o_tok
);
    typedef enum logic [5:0] {
        PH_HDR    = 6'b000001,
        PH_CMD    = 6'b000010,
        PH_REFLO  = 6'b000100,
        PH_REFEXT = 6'b001000,
        PH_LITEXT = 6'b010000,
        PH_LIT    = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_hidx, n_hidx;
    logic [8:0] r_pend, n_pend;
    logic [2:0] r_offhi, n_offhi;
    logic [7:0] r_offlo, n_offlo;
    logic [7:0] b;
    logic [4:0] run_n;

    assign b = i_item.in_byte;
    assign run_n = {1'b0, ~b[3:0]} + 5'd1;

    always_comb begin
        n_phase = r_phase;
        n_hidx  = r_hidx;
        n_pend  = r_pend;
        n_offhi = r_offhi;
        n_offlo = r_offlo;
        o_tok       = '0;
        o_tok.kind  = sld_pkg::TK_NONE;
        o_tok.tbyte = b;
        o_tok.hidx  = r_hidx;
        o_tok.last  = i_item.in_last;
        unique case (r_phase)
            PH_CMD: begin
                if (!b[4]) begin
                    n_offhi = b[7:5];
                    n_pend  = {5'd0, b[3:0]} + 9'd3;
                    n_phase = PH_REFLO;
                end else if (b == 8'hFF) begin
                    o_tok.kind = sld_pkg::TK_END;
                end else begin
                    n_pend  = {4'd0, run_n};
                    n_phase = (run_n == 5'd16) ? PH_LITEXT : PH_LIT;
                end
            end
            PH_REFLO: begin
                n_offlo = b;
                if (r_pend == 9'd18) begin
                    n_phase = PH_REFEXT;
                end else begin
                    o_tok.kind = sld_pkg::TK_COPY;
                    o_tok.span = 12'd2048 - {1'b0, r_offhi, 8'd0} - {4'd0, b};
                    o_tok.len  = r_pend;
                    n_phase    = PH_CMD;
                end
            end
            PH_REFEXT: begin
                o_tok.kind = sld_pkg::TK_COPY;
                o_tok.span = 12'd2048 - {1'b0, r_offhi, 8'd0} - {4'd0, r_offlo};
                o_tok.len  = 9'd18 + {1'b0, b};
                n_phase    = PH_CMD;
            end
            PH_LITEXT: begin
                n_pend  = r_pend + {1'b0, b};
                n_phase = PH_LIT;
            end
            PH_LIT: begin
                n_pend = (r_pend != 9'd0) ? r_pend - 9'd1 : 9'd0;
                o_tok.kind = sld_pkg::TK_LIT;
                o_tok.more = (n_pend != 9'd0);
                if (n_pend == 9'd0) begin
                    n_phase = PH_CMD;
                end
            end
            default: begin
                o_tok.kind = sld_pkg::TK_HDR;
                n_hidx = r_hidx + 3'd1;
                if (n_hidx == 3'(sld_pkg::HEADER_BYTES)) begin
                    n_phase = PH_CMD;
                end
            end
        endcase
        // every stream ends at its last byte: start over with a header
        if (i_item.in_last) begin
            n_phase = PH_HDR;
            n_hidx  = '0;
            n_pend  = '0;
            n_offhi = '0;
            n_offlo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_hidx  <= '0;
            r_pend  <= '0;
            r_offhi <= '0;
            r_offlo <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_pend  <= n_pend;
            r_offhi <= n_offhi;
            r_offlo <= n_offlo;
        end
    end
endmodule

/* sv/sld_fifo.sv */
`timescale 1ns / 1ps
// sld_fifo: two-entry token queue between parser and executor.
// Depends on sld_pkg.
module sld_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sld_pkg::t_token i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sld_pkg::t_token o_head
);
    sld_pkg::t_token r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

/* sv/sld_back.sv */
`timescale 1ns / 1ps
// sld_back: executes tokens, owns the history window and packs result bytes.
// Depends on sld_pkg and sld_ram.
module sld_back #(
    parameter int BYTES_PER_RESULT = sld_pkg::BYTES_PER_RESULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tok_valid,
    input  sld_pkg::t_token    i_tok,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sld_pkg::t_out_item o_out_item
);
    localparam int AW = sld_pkg::WIN_AW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic        r_finished, n_finished;
    logic [31:0] r_produced, n_produced;
    logic [31:0] r_declared, n_declared;
    logic [AW-1:0] r_wp, n_wp;
    logic [11:0] r_dist, n_dist;
    logic [8:0]  r_left, n_left;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_pre, n_pre;
    logic        r_ended, n_ended;
    logic        r_trunc, n_trunc;
    logic        r_rd_pre, n_rd_pre;
    logic        r_out_valid, n_out_valid;
    sld_pkg::t_out_item r_out, n_out;

    logic          we;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          can_emit, out_load, size_hit;
    logic [31:0]   decl_new, prod_inc;
    logic [7:0]    v;

    sld_ram #(.WIDTH(8), .DEPTH(sld_pkg::WINDOW_BYTES)) u_hist (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wp),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign raddr    = r_wp - r_dist[AW-1:0];
    assign can_emit = !r_out_valid || !i_out_stall;
    assign size_hit = (r_produced >= r_declared);
    assign prod_inc = r_produced + 32'd1;
    assign v        = r_rd_pre ? 8'd0 : rdata;

    always_comb begin
        decl_new = r_declared;
        case (i_tok.hidx)
            3'd0: decl_new[7:0]   = r_declared[7:0]   | i_tok.tbyte;
            3'd1: decl_new[15:8]  = r_declared[15:8]  | i_tok.tbyte;
            3'd2: decl_new[23:16] = r_declared[23:16] | i_tok.tbyte;
            3'd3: decl_new[31:24] = r_declared[31:24] | i_tok.tbyte;
            default: decl_new = r_declared;
        endcase
    end

    always_comb begin
        n_state = r_state;   n_finished = r_finished;
        n_produced = r_produced; n_declared = r_declared; n_wp = r_wp;
        n_dist = r_dist;     n_left = r_left;   n_acc = r_acc;
        n_cnt = r_cnt;       n_pre = r_pre;     n_ended = r_ended;
        n_trunc = r_trunc;   n_rd_pre = r_rd_pre;
        n_out = r_out;       out_load = 1'b0;
        o_pop = 1'b0;        we = 1'b0;         wdata = 8'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    n_acc = '0; n_cnt = '0; n_pre = 1'b0;
                    n_ended = i_tok.last; n_trunc = 1'b0;
                    if (r_finished) begin
                        o_pop = 1'b1;
                        if (i_tok.last) begin
                            n_finished = 1'b0; n_produced = '0;
                            n_declared = '0;   n_wp = '0;
                        end
                    end else begin
                        unique case (i_tok.kind)
                            sld_pkg::TK_HDR: begin
                                n_declared = decl_new;
                                if ((i_tok.hidx == 3'(sld_pkg::HEADER_BYTES - 1)
                                     && decl_new == 32'd0) || i_tok.last) begin
                                    n_ended = 1'b1;
                                    n_state = S_FIN;
                                end else begin
                                    o_pop = 1'b1;
                                end
                            end
                            sld_pkg::TK_END: begin
                                n_ended = 1'b1;
                                n_state = S_FIN;
                            end
                            sld_pkg::TK_LIT: begin
                                we = 1'b1; wdata = i_tok.tbyte;
                                n_wp = r_wp + 1'b1; n_produced = prod_inc;
                                n_acc = {56'd0, i_tok.tbyte}; n_cnt = 4'd1;
                                n_ended = (prod_inc >= r_declared) || i_tok.last;
                                n_trunc = (prod_inc >= r_declared) && i_tok.more;
                                n_state = S_FIN;
                            end
                            sld_pkg::TK_COPY: begin
                                n_dist = i_tok.span; n_left = i_tok.len;
                                n_state = S_RD;
                            end
                            default: begin
                                if (i_tok.last) begin
                                    n_state = S_FIN;
                                end else begin
                                    o_pop = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                if (r_left == 9'd0 || size_hit) begin
                    n_trunc = (r_left != 9'd0);
                    n_ended = size_hit || i_tok.last;
                    n_state = S_FIN;
                end else if (r_cnt == 4'(BYTES_PER_RESULT)) begin
                    if (can_emit) begin
                        out_load = 1'b1;
                        n_out = '{r_acc, r_cnt, 1'b0, 1'b0,
                                  r_pre ? sld_pkg::ST_PRESTART : sld_pkg::ST_OK};
                        n_acc = '0; n_cnt = '0; n_pre = 1'b0;
                    end
                end else begin
                    n_rd_pre = ({20'd0, r_dist} > r_produced);
                    n_state  = S_WR;
                end
            end
            S_WR: begin
                we = 1'b1; wdata = v;
                for (int k = 0; k < 8; k++) begin
                    if (r_cnt == 4'(k)) n_acc[8*k +: 8] = v;
                end
                n_cnt = r_cnt + 4'd1;
                n_pre = r_pre | r_rd_pre;
                n_wp = r_wp + 1'b1; n_produced = prod_inc;
                n_left = r_left - 9'd1;
                n_state = S_RD;
            end
            default: begin
                if (can_emit) begin
                    if (r_cnt != 4'd0 || r_ended) begin
                        out_load = 1'b1;
                        n_out = '{r_acc, r_cnt, 1'b1, r_ended,
                                  r_pre ? sld_pkg::ST_PRESTART :
                                  (r_trunc ? sld_pkg::ST_TRUNC : sld_pkg::ST_OK)};
                    end
                    n_acc = '0; n_cnt = '0; n_pre = 1'b0;
                    o_pop = 1'b1;
                    if (r_ended) begin
                        if (i_tok.last) begin
                            n_produced = '0; n_declared = '0; n_wp = '0;
                        end else begin
                            n_finished = 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
        endcase
        if (out_load)         n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_finished  <= 1'b0;
            r_produced  <= '0;
            r_declared  <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_pre       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_finished  <= n_finished;
            r_produced  <= n_produced;
            r_declared  <= n_declared;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_pre       <= n_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist   <= n_dist;
        r_left   <= n_left;
        r_acc    <= n_acc;
        r_ended  <= n_ended;
        r_trunc  <= n_trunc;
        r_rd_pre <= n_rd_pre;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.out_count <= 4'(BYTES_PER_RESULT))
        else $error("result holds more bytes than allowed");
    a_partial_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.run_last) |-> r_out.out_count == 4'(BYTES_PER_RESULT))
        else $error("non-final result is not full");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stream_done) |-> r_out.run_last)
        else $error("stream end on a non-final result");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> r_state == S_IDLE)
        else $error("executor busy after stream end");
`endif
endmodule

/* sv/sld_lz_decompressor.sv */
`timescale 1ns / 1ps
// sld_lz_decompressor: top level of the streaming LZ decompressor, 2 KiB window.
// Depends on sld_pkg, sld_front, sld_fifo, sld_back (which uses sld_ram).
//
//  channel | direction | payload            | handshake
//  in      | input     | t_in_item  (byte)  | i_in_valid / o_in_stall
//  out     | output    | t_out_item (<=8 B) | o_out_valid / i_out_stall
//
// The executor consumes a header or command byte in S_IDLE; a literal also
// passes S_FIN. A back-reference runs S_RD and S_WR for each copied byte, then
// S_FIN: the window RAM read is registered, so each read precedes its write.
// The two-entry token queue lets the parser keep taking requests meanwhile.
// Reset: synchronous, active low; history content is undefined until written.
// Stalls: the output register holds a result under i_out_stall and the executor
// waits; the input stalls only when the token queue is full.
module sld_lz_decompressor #(
    parameter int BYTES_PER_RESULT = sld_pkg::BYTES_PER_RESULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sld_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sld_pkg::t_out_item o_out_item
);
    sld_pkg::t_token tok_in, tok_head;
    logic            q_full, q_valid, q_pop, in_fire;

    // a request is taken whenever the queue has room
    assign o_in_stall = q_full;
    assign in_fire    = i_in_valid && !q_full;

    sld_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (in_fire),
        .i_item (i_in_item),
        .o_tok  (tok_in)
    );

    sld_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_fire),
        .i_data (tok_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_head (tok_head)
    );

    sld_back #(.BYTES_PER_RESULT(BYTES_PER_RESULT)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok_valid(q_valid),
        .i_tok      (tok_head),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );
endmodule
